FILE: rtl/rrb_pkg.sv
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared constants for the reorder receive buffer: field widths, register
// map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rrb_pkg;

	// default number of packet slots
	localparam int DEPTH_DEF = 16;

	// field widths
	localparam int SEQ_W  = 32;
	localparam int TYPE_W = 8;
	localparam int PAY_W  = 32;
	localparam int OCC_W  = 5;
	localparam int WIN_W  = 5;

	// one stored slot: {payload, type, seq}
	localparam int ENTRY_W = SEQ_W + TYPE_W + PAY_W;

	// stream payload widths
	localparam int S_TDATA_W = ENTRY_W;
	localparam int M_TDATA_W = ((ENTRY_W + OCC_W + 7) / 8) * 8;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [APB_AW-3:0] REG_WINDOW = 1'b0;

	// reset value of window_size
	localparam logic [WIN_W-1:0] WINDOW_RST = 5'd16;

	// item kinds on s_tuser
	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/reorder_receive_buffer.sv
// ----------------------------------------------------------------------------
// reorder_receive_buffer
// Out-of-order receive window: stores packets into the lowest free slot and
// fetches them back by sequence number, one slot compare per clock.
// ----------------------------------------------------------------------------
// An item is taken only while the sequencer is idle. Its result is offered after a
// scan state, in which a single comparator walks the slot memory one entry per
// cycle (the slot memory has one registered read port), and a write-back state.
// The block takes no new item until the result has been handed over, and it stays
// busy for as long as m_tready holds the result off. s_tready is high only between
// items; the next item is taken in the cycle after the result is handed over.
`default_nettype none

module reorder_receive_buffer #(
	parameter int DEPTH = rrb_pkg::DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rrb_pkg::APB_AW-1:0]     paddr,
	input  wire logic [rrb_pkg::APB_DW-1:0]     pwdata,
	output logic      [rrb_pkg::APB_DW-1:0]     prdata,
	output logic                                pready,
	// input items
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// seq_num_in[31:0], pkt_type[39:32], payload_in[71:40]
	input  wire logic [rrb_pkg::S_TDATA_W-1:0]  s_tdata,
	// mode[0]
	input  wire logic                           s_tuser,
	// result items
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// seq_out[31:0], type_out[39:32], payload_out[71:40], occupied[76:72], zero pad
	output logic      [rrb_pkg::M_TDATA_W-1:0]  m_tdata,
	// ok[0]
	output logic                                m_tuser
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (IW + 1 > rrb_pkg::WIN_W) ? IW + 1 : rrb_pkg::WIN_W;
	localparam int SW = rrb_pkg::SEQ_W;
	localparam int TW = rrb_pkg::TYPE_W;
	localparam int PW = rrb_pkg::PAY_W;
	localparam int OW = rrb_pkg::OCC_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

	state_t                      state_q;
	logic [rrb_pkg::WIN_W-1:0]   window_q;

	// item captured at acceptance
	logic                        mode_q;
	logic [SW-1:0]               seq_q;
	logic [TW-1:0]               type_q;
	logic [PW-1:0]               pay_q;

	// scan sequencer
	logic [CW-1:0]               scan_q;
	logic                        pipe_s1;
	logic [IW-1:0]               idx_s1;
	logic                        vld_s1;
	logic [rrb_pkg::ENTRY_W-1:0] rd_s1;

	// scan results
	logic                        hit_q;
	logic [IW-1:0]               hit_idx_q;
	logic [TW-1:0]               hit_type_q;
	logic [PW-1:0]               hit_pay_q;
	logic                        free_q;
	logic [IW-1:0]               free_idx_q;
	logic [OW-1:0]               cnt_q;

	// slot storage
	logic [DEPTH-1:0]            slot_vld_q;
	logic [rrb_pkg::ENTRY_W-1:0] slot_mem_q [DEPTH];

	// result register
	logic                        m_valid_q;
	logic                        ok_q;
	logic [SW-1:0]               seq_out_q;
	logic [TW-1:0]               type_out_q;
	logic [PW-1:0]               pay_out_q;
	logic [OW-1:0]               occ_q;

	logic [CW-1:0]               lim_w;
	logic [IW-1:0]               scan_idx;
	logic                        scan_more;
	logic                        match_w;
	logic                        store_ok;
	logic                        fetch_ok;
	logic                        cfg_wr;

	// slots in use: window saturated to the slot count
	always_comb begin
		if (CW'(window_q) > CW'(DEPTH)) begin
			lim_w = CW'(DEPTH);
		end else begin
			lim_w = CW'(window_q);
		end
	end

	assign scan_idx  = scan_q[IW-1:0];
	assign scan_more = (scan_q < lim_w);
	assign match_w   = pipe_s1 && vld_s1 && (rd_s1[SW-1:0] == seq_q) && !hit_q;
	assign store_ok  = (mode_q == rrb_pkg::MODE_STORE) && !hit_q && free_q;
	assign fetch_ok  = (mode_q == rrb_pkg::MODE_FETCH) && hit_q;

	// configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[rrb_pkg::APB_AW-1:2] == rrb_pkg::REG_WINDOW) begin
			prdata = rrb_pkg::APB_DW'(window_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= rrb_pkg::WINDOW_RST;
		end else if (cfg_wr && paddr[rrb_pkg::APB_AW-1:2] == rrb_pkg::REG_WINDOW) begin
			window_q <= pwdata[rrb_pkg::WIN_W-1:0];
		end
	end

	// sequencer, valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= rrb_pkg::MODE_STORE;
			seq_q      <= '0;
			type_q     <= '0;
			pay_q      <= '0;
			scan_q     <= '0;
			pipe_s1    <= 1'b0;
			idx_s1     <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			cnt_q      <= '0;
			slot_vld_q <= '0;
			m_valid_q  <= 1'b0;
			ok_q       <= 1'b0;
			seq_out_q  <= '0;
			type_out_q <= '0;
			pay_out_q  <= '0;
			occ_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q  <= s_tuser;
						seq_q   <= s_tdata[SW-1:0];
						type_q  <= s_tdata[SW+TW-1:SW];
						pay_q   <= s_tdata[SW+TW+PW-1:SW+TW];
						scan_q  <= '0;
						pipe_s1 <= 1'b0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue side: one slot read per cycle
					pipe_s1 <= scan_more;
					if (scan_more) begin
						idx_s1 <= scan_idx;
						vld_s1 <= slot_vld_q[scan_idx];
						scan_q <= scan_q + CW'(1);
					end
					// compare side: slot read in the previous cycle
					if (pipe_s1) begin
						if (vld_s1) begin
							cnt_q <= cnt_q + OW'(1);
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					if (match_w) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (!scan_more) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					ok_q       <= store_ok || fetch_ok;
					seq_out_q  <= fetch_ok ? seq_q : '0;
					type_out_q <= fetch_ok ? hit_type_q : '0;
					pay_out_q  <= fetch_ok ? hit_pay_q : '0;
					if (store_ok) begin
						slot_vld_q[free_idx_q] <= 1'b1;
						occ_q <= cnt_q + OW'(1);
					end else if (fetch_ok) begin
						slot_vld_q[hit_idx_q] <= 1'b0;
						occ_q <= cnt_q - OW'(1);
					end else begin
						occ_q <= cnt_q;
					end
					m_valid_q <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && scan_more) begin
			rd_s1 <= slot_mem_q[scan_idx];
		end
		if (state_q == ST_WRITE && store_ok) begin
			slot_mem_q[free_idx_q] <= {pay_q, type_q, seq_q};
		end
	end

	// contents of the matching slot
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && match_w) begin
			hit_type_q <= rd_s1[SW+TW-1:SW];
			hit_pay_q  <= rd_s1[SW+TW+PW-1:SW+TW];
		end
	end

	// ports
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = rrb_pkg::M_TDATA_W'({occ_q, pay_out_q, type_out_q, seq_out_q});

	// checks
	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !m_valid_q)
		else $error("result pending while sequencer idle");

	a_occ_within_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (CW'(occ_q) <= lim_w))
		else $error("occupied count exceeds slots in use");

	a_fetch_seq_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && ok_q && mode_q == rrb_pkg::MODE_FETCH) |-> (seq_out_q == seq_q))
		else $error("fetched sequence number differs from request");

	a_store_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && mode_q == rrb_pkg::MODE_STORE) |->
		(seq_out_q == '0 && type_out_q == '0 && pay_out_q == '0))
		else $error("store result carries packet data");

	a_store_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && store_ok) |=> slot_vld_q[free_idx_q])
		else $error("stored slot not marked valid");

endmodule

`default_nettype wire

FILE: test/reorder_receive_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_receive_buffer_test
// Self-checking bench for the reorder receive buffer. A queue of packets,
// directed corner cases first and then pooled random traffic over a range of
// window sizes, feeds a stream driver. A shadow copy of the slot window
// predicts every reply, and a monitor compares the replies field by field.
// ----------------------------------------------------------------------------

module reorder_receive_buffer_test;

	localparam int SLOTS = rrb_pkg::DEPTH_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int LONG_HOLD_AT = 150;
	localparam int TAIL_CYCLES = 40;

	// register index just past the map, writes there are dropped
	localparam logic [rrb_pkg::APB_AW-3:0] REG_UNMAPPED = 1'b1;

	typedef struct {
		logic                      mode;
		logic [rrb_pkg::SEQ_W-1:0]  seq;
		logic [rrb_pkg::TYPE_W-1:0] ptype;
		logic [rrb_pkg::PAY_W-1:0]  payload;
		bit                         drain;
	} packet_t;

	typedef struct {
		logic                       ok;
		logic [rrb_pkg::SEQ_W-1:0]  seq;
		logic [rrb_pkg::TYPE_W-1:0] ptype;
		logic [rrb_pkg::PAY_W-1:0]  payload;
		logic [rrb_pkg::OCC_W-1:0]  occupied;
	} reply_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [rrb_pkg::APB_AW-1:0]      paddr = '0;
	logic [rrb_pkg::APB_DW-1:0]      pwdata = '0;
	logic [rrb_pkg::APB_DW-1:0]      prdata;
	logic                            pready;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	// seq_num_in[31:0], pkt_type[39:32], payload_in[71:40]
	logic [rrb_pkg::S_TDATA_W-1:0]   s_tdata = '0;
	// mode[0]
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// seq_out[31:0], type_out[39:32], payload_out[71:40], occupied[76:72]
	logic [rrb_pkg::M_TDATA_W-1:0]   m_tdata;
	// ok[0]
	logic                            m_tuser;

	// shadow copy of the slot window
	logic [rrb_pkg::WIN_W-1:0]  shadow_window = rrb_pkg::WINDOW_RST;
	bit                         shadow_valid [SLOTS];
	logic [rrb_pkg::SEQ_W-1:0]  shadow_seq [SLOTS];
	logic [rrb_pkg::TYPE_W-1:0] shadow_type [SLOTS];
	logic [rrb_pkg::PAY_W-1:0]  shadow_payload [SLOTS];

	packet_t packet_queue [$];
	reply_t  awaited_replies [$];
	packet_t current_packet;
	bit      offering = 1'b0;
	int      send_gap = 0;
	int      send_calm = 0;
	int      recv_stall = 0;
	int      recv_calm = 0;
	int      long_hold = 0;
	int      replies_seen = 0;
	int      mismatches = 0;
	int      cycle_count = 0;

	reorder_receive_buffer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// store into the lowest free slot or fetch and free by sequence number
	function automatic reply_t window_lookup(packet_t p);
		reply_t r;
		int lim;
		int hit;
		r = '{default: '0};
		lim = (shadow_window > SLOTS) ? SLOTS : int'(shadow_window);
		hit = -1;
		for (int i = 0; i < lim; i++)
			if (hit < 0 && shadow_valid[i] && shadow_seq[i] == p.seq)
				hit = i;
		if (p.mode == rrb_pkg::MODE_STORE) begin
			if (hit < 0) begin
				for (int i = 0; i < lim; i++) begin
					if (!r.ok && !shadow_valid[i]) begin
						shadow_valid[i] = 1'b1;
						shadow_seq[i] = p.seq;
						shadow_type[i] = p.ptype;
						shadow_payload[i] = p.payload;
						r.ok = 1'b1;
					end
				end
			end
		end else if (hit >= 0) begin
			r.ok = 1'b1;
			r.seq = shadow_seq[hit];
			r.ptype = shadow_type[hit];
			r.payload = shadow_payload[hit];
			shadow_valid[hit] = 1'b0;
		end
		for (int i = 0; i < lim; i++)
			if (shadow_valid[i])
				r.occupied++;
		return r;
	endfunction

	// idle cycles before the next item, with bursts of no idling
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch on reply %0d: %s got %h expected %h", replies_seen, what, got, want);
	endtask

	task automatic compare_reply();
		reply_t want;
		if (awaited_replies.size() == 0) begin
			report_mismatch("reply with no item outstanding", '0, '0);
			return;
		end
		want = awaited_replies.pop_front();
		if (m_tuser !== want.ok)
			report_mismatch("ok", 32'(m_tuser), 32'(want.ok));
		if (m_tdata[rrb_pkg::SEQ_W-1:0] !== want.seq)
			report_mismatch("seq_out", m_tdata[rrb_pkg::SEQ_W-1:0], want.seq);
		if (m_tdata[rrb_pkg::SEQ_W +: rrb_pkg::TYPE_W] !== want.ptype)
			report_mismatch("type_out", 32'(m_tdata[rrb_pkg::SEQ_W +: rrb_pkg::TYPE_W]),
				32'(want.ptype));
		if (m_tdata[rrb_pkg::SEQ_W+rrb_pkg::TYPE_W +: rrb_pkg::PAY_W] !== want.payload)
			report_mismatch("payload_out",
				m_tdata[rrb_pkg::SEQ_W+rrb_pkg::TYPE_W +: rrb_pkg::PAY_W], want.payload);
		if (m_tdata[rrb_pkg::ENTRY_W +: rrb_pkg::OCC_W] !== want.occupied)
			report_mismatch("occupied", 32'(m_tdata[rrb_pkg::ENTRY_W +: rrb_pkg::OCC_W]),
				32'(want.occupied));
	endtask

	// stream driver, predicts each packet as it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
			send_gap = 0;
		end else begin
			if (offering && s_tready) begin
				awaited_replies.push_back(window_lookup(current_packet));
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (packet_queue.size() != 0 &&
						!(packet_queue[0].drain && awaited_replies.size() != 0)) begin
					current_packet = packet_queue.pop_front();
					s_tdata <= {current_packet.payload, current_packet.ptype, current_packet.seq};
					s_tuser <= current_packet.mode;
					offering = 1'b1;
					send_gap = draw_gap(send_calm);
				end
			end
			s_tvalid <= offering;
		end
	end

	// reply monitor with random stalls and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
			long_hold = 0;
		end else begin
			if (long_hold > 0)
				long_hold--;
			else if (recv_stall > 0)
				recv_stall--;
			if (m_tvalid && m_tready) begin
				compare_reply();
				replies_seen++;
				recv_stall = draw_gap(recv_calm);
				if (replies_seen == LONG_HOLD_AT)
					long_hold = LONG_HOLD_CYCLES;
			end
			m_tready <= (long_hold == 0 && recv_stall == 0);
		end
	end

	task automatic queue_packet(logic mode, logic [rrb_pkg::SEQ_W-1:0] seq,
			logic [rrb_pkg::TYPE_W-1:0] ptype, logic [rrb_pkg::PAY_W-1:0] payload);
		packet_t p;
		p.mode = mode;
		p.seq = seq;
		p.ptype = ptype;
		p.payload = payload;
		p.drain = 1'b0;
		packet_queue.push_back(p);
	endtask

	// random traffic drawn mostly from a small pool of sequence numbers
	task automatic queue_random_phase(int count, int pool_size);
		logic [rrb_pkg::SEQ_W-1:0] pool [$];
		packet_t p;
		for (int k = 0; k < pool_size; k++)
			pool.push_back($urandom);
		for (int n = 0; n < count; n++) begin
			p.mode = ($urandom_range(0, 99) < 55) ? rrb_pkg::MODE_STORE : rrb_pkg::MODE_FETCH;
			if ($urandom_range(0, 9) == 0)
				p.seq = $urandom;
			else
				p.seq = pool[$urandom_range(0, pool_size - 1)];
			p.ptype = rrb_pkg::TYPE_W'($urandom);
			p.payload = $urandom;
			p.drain = (n == count / 2) || ($urandom_range(0, 39) == 0);
			packet_queue.push_back(p);
		end
	endtask

	// wait until every packet is sent and every reply is back
	task automatic settle();
		while (packet_queue.size() != 0 || awaited_replies.size() != 0 || offering)
			@(negedge clk);
	endtask

	task automatic write_register(logic [rrb_pkg::APB_AW-3:0] index,
			logic [rrb_pkg::APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == rrb_pkg::REG_WINDOW)
			shadow_window = value[rrb_pkg::WIN_W-1:0];
	endtask

	initial begin
		automatic int windows [9] = '{7, 16, 1, 4, 31, 10, 2, 0, 16};
		automatic int counts [9] = '{70, 70, 50, 70, 70, 70, 60, 12, 70};
		int pool_size;

		for (int i = 0; i < SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_seq[i] = '0;
			shadow_type[i] = '0;
			shadow_payload[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// full window: extremes, duplicate, hit, miss
		queue_packet(rrb_pkg::MODE_STORE, 32'h0000_0000, 8'h00, 32'h0000_0000);
		queue_packet(rrb_pkg::MODE_STORE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		queue_packet(rrb_pkg::MODE_STORE, 32'h0000_0000, 8'h11, 32'h1111_1111);
		queue_packet(rrb_pkg::MODE_FETCH, 32'hFFFF_FFFF, 8'hAA, 32'h5555_5555);
		queue_packet(rrb_pkg::MODE_FETCH, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000);
		queue_packet(rrb_pkg::MODE_FETCH, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF);
		queue_packet(rrb_pkg::MODE_FETCH, 32'h1234_5678, 8'h00, 32'h0000_0000);
		settle();

		// two slots: fill, refuse when full, reuse the freed slot
		write_register(rrb_pkg::REG_WINDOW, 32'd2);
		queue_packet(rrb_pkg::MODE_STORE, 32'h0000_0001, 8'h01, 32'hCAFE_0001);
		queue_packet(rrb_pkg::MODE_STORE, 32'hA5A5_A5A5, 8'hA5, 32'hA5A5_A5A5);
		queue_packet(rrb_pkg::MODE_STORE, 32'h5A5A_5A5A, 8'h5A, 32'h5A5A_5A5A);
		queue_packet(rrb_pkg::MODE_FETCH, 32'h0000_0001, 8'h00, 32'h0000_0000);
		queue_packet(rrb_pkg::MODE_STORE, 32'h5A5A_5A5A, 8'h5A, 32'h5A5A_5A5A);
		settle();

		// shrunk window hides the upper slot
		write_register(rrb_pkg::REG_WINDOW, 32'd1);
		queue_packet(rrb_pkg::MODE_FETCH, 32'hA5A5_A5A5, 8'h00, 32'h0000_0000);
		queue_packet(rrb_pkg::MODE_STORE, 32'hA5A5_A5A5, 8'h77, 32'h7777_7777);
		queue_packet(rrb_pkg::MODE_FETCH, 32'h5A5A_5A5A, 8'h00, 32'h0000_0000);
		queue_packet(rrb_pkg::MODE_STORE, 32'h7FFF_FFFF, 8'h7F, 32'h8000_0000);
		settle();

		// empty window refuses everything
		write_register(rrb_pkg::REG_WINDOW, 32'd0);
		queue_packet(rrb_pkg::MODE_STORE, 32'hDEAD_BEEF, 8'h42, 32'h0BAD_F00D);
		queue_packet(rrb_pkg::MODE_FETCH, 32'h7FFF_FFFF, 8'h00, 32'h0000_0000);
		settle();

		// unmapped register ignored, oversized window saturates
		write_register(REG_UNMAPPED, 32'd3);
		write_register(rrb_pkg::REG_WINDOW, 32'hFFFF_FFFF);
		queue_packet(rrb_pkg::MODE_FETCH, 32'hA5A5_A5A5, 8'h00, 32'h0000_0000);
		queue_packet(rrb_pkg::MODE_FETCH, 32'h7FFF_FFFF, 8'h00, 32'h0000_0000);
		queue_packet(rrb_pkg::MODE_STORE, 32'h8000_0000, 8'h80, 32'h5555_5555);
		settle();
		write_register(rrb_pkg::REG_WINDOW, 32'd16);
		queue_packet(rrb_pkg::MODE_FETCH, 32'h8000_0000, 8'h00, 32'h0000_0000);
		settle();

		// random phases over a range of windows, junk in the upper data bits
		for (int ph = 0; ph < 9; ph++) begin
			write_register(rrb_pkg::REG_WINDOW, ($urandom & ~32'h1F) | windows[ph]);
			pool_size = ((windows[ph] > SLOTS) ? SLOTS : windows[ph]) + 4;
			queue_random_phase(counts[ph], pool_size);
			settle();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
